@@ sv/rtu_pkg.sv @@
// ============================================================================
// rtu_pkg: shared types and constants of the fixed-point tanh pipeline
// sideband bundle that travels with each beat, widths of the internal
// fixed-point words and default parameter values
// ============================================================================
package rtu_pkg;

  localparam int DATA_WIDTH_DEF   = 16;
  localparam int IN_FRAC_BITS_DEF = 12;

  // register stages of the exponential front end
  localparam int EXP_STAGES = 16;

  // width of the divisor 2^32 + E, which can reach 2^33
  localparam int DEN_W = 34;

  // one in q0.32, carried as a 33-bit word
  localparam logic [32:0] Q32_ONE = 33'h1_0000_0000;

  // control and flag bits that follow a beat down the pipe
  typedef struct packed {
    logic valid;
    logic last;
    logic neg;
    logic zero;
    logic sat;
  } side_t;

endpackage

@@ sv/rtu_exp.sv @@
// ============================================================================
// rtu_exp: exponential front end
// takes |x| to E = e^(-2|x|) through a base-two split, a short taylor series
// and four squarings, then forms the rounded dividend and the divisor
// ============================================================================
module rtu_exp
  import rtu_pkg::*;
#(
  parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
  parameter int IN_FRAC_BITS = IN_FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [DATA_WIDTH-1:0]  in_x,
  input  logic                   in_last,
  output side_t                  out_side,
  output logic [DATA_WIDTH+31:0] out_n,
  output logic [DEN_W-1:0]       out_d
);

  localparam int          NUM_W   = DATA_WIDTH + 32;
  localparam logic [63:0] SAT_LIM = 64'd16 << IN_FRAC_BITS;
  localparam int          LSH     = (IN_FRAC_BITS <= 24) ? 24 - IN_FRAC_BITS : 0;
  localparam int          RSH     = (IN_FRAC_BITS > 24) ? IN_FRAC_BITS - 24 : 0;

  // 2*log2(e) in q2.32 less its top bit, ln2 in q0.32, reciprocals of 3 and 5
  localparam logic [31:0] C1_LO   = 32'd3802721445;
  localparam logic [31:0] C2      = 32'd2977044472;
  localparam logic [31:0] RECIP3  = 32'hAAAA_AAAB;
  localparam logic [31:0] RECIP5  = 32'hCCCC_CCCD;

  // (h * t) >> 32 for one horner step
  function automatic logic [27:0] hmul(input logic [27:0] h, input logic [32:0] t);
    logic [60:0] prod;
    prod = 61'(h) * 61'(t);
    return prod[59:32];
  endfunction

  // rounded q0.32 square, one stays one
  function automatic logic [32:0] sq_q32(input logic [32:0] e);
    logic [63:0] prod;
    prod = 64'(e[31:0]) * 64'(e[31:0]) + 64'h8000_0000;
    if (e[32]) begin
      return Q32_ONE;
    end
    return 33'(prod[63:32]);
  endfunction

  side_t side_r [1:EXP_STAGES];
  side_t side_nxt;

  logic [5:0]  k_r   [3:14];
  logic [27:0] h_r   [4:9];

  logic [27:0] a24_r, a24b_r;
  logic [59:0] pm_r;
  logic [31:0] f_r;
  logic [25:0] q5_r;
  logic [27:0] m4_r, m3_r, m2_r, m1_r;
  logic [26:0] q3_r;
  logic [32:0] e1_r, e2_r, e3_r, e4_r, big_r;
  logic [NUM_W-1:0] n_r;
  logic [DEN_W-1:0] d_r;

  // stage 1: magnitude, flags and rescale to 24 fraction bits
  logic                  neg_s0;
  logic [DATA_WIDTH-1:0] a_s0;
  logic [63:0]           a_wide;
  logic [27:0]           a24_nxt;

  assign neg_s0  = in_x[DATA_WIDTH-1];
  assign a_s0    = neg_s0 ? (~in_x + 1'b1) : in_x;
  assign a_wide  = (64'(a_s0) << LSH) >> RSH;
  assign a24_nxt = a_wide[27:0];

  always_comb begin
    side_nxt.valid = in_valid;
    side_nxt.last  = in_last;
    side_nxt.neg   = neg_s0;
    side_nxt.zero  = (a_s0 == '0);
    side_nxt.sat   = (64'(a_s0) >= SAT_LIM);
  end

  // stage 2: low part of a24 * 2*log2(e)
  logic [59:0] pm_nxt;
  assign pm_nxt = 60'(a24_r) * 60'(C1_LO);

  // stage 3: integer and fraction of the base-two exponent
  logic [61:0] p_s3;
  assign p_s3 = {1'b0, a24b_r, 33'd0} + {2'd0, pm_r};

  // stage 4: fraction back to natural units, then /16
  logic [63:0] g_s4;
  logic [27:0] h_nxt;
  assign g_s4  = 64'(f_r) * 64'(C2);
  assign h_nxt = g_s4[63:36];

  // stage 5: h / 5
  logic [59:0] q5_prod;
  assign q5_prod = 60'(h_r[4]) * 60'(RECIP5);

  // stages 6 to 10: remaining horner steps
  logic [27:0] m4_nxt, m3_nxt, m2_nxt, m1_nxt;
  logic [26:0] q3_nxt;
  logic [59:0] q3_prod;

  assign m4_nxt  = hmul(h_r[5], Q32_ONE - 33'(q5_r));
  assign m3_nxt  = hmul(h_r[6], Q32_ONE - 33'(m4_r >> 2));
  assign q3_prod = 60'(m3_r) * 60'(RECIP3);
  assign q3_nxt  = q3_prod[59:33];
  assign m2_nxt  = hmul(h_r[8], Q32_ONE - 33'(q3_r));
  assign m1_nxt  = hmul(h_r[9], Q32_ONE - 33'(m2_r >> 1));

  // stages 11 to 14: raise to the 16th power
  logic [32:0] e1_nxt, e2_nxt, e3_nxt, e4_nxt;
  assign e1_nxt = sq_q32(Q32_ONE - 33'(m1_r));
  assign e2_nxt = sq_q32(e1_r);
  assign e3_nxt = sq_q32(e2_r);
  assign e4_nxt = sq_q32(e3_r);

  // stage 15: scale by 2^-k with round half up
  logic [33:0] rnd_s15;
  logic [32:0] big_nxt;

  always_comb begin
    rnd_s15 = 34'(e4_r) + (34'd1 << (k_r[14] - 6'd1));
    if (k_r[14] == 6'd0) begin
      big_nxt = e4_r;
    end else if (k_r[14] >= 6'd40) begin
      big_nxt = '0;
    end else begin
      big_nxt = 33'(rnd_s15 >> k_r[14]);
    end
  end

  // stage 16: dividend with half divisor added, and divisor
  logic [NUM_W-1:0] n_nxt;
  logic [DEN_W-1:0] d_nxt;

  assign d_nxt = DEN_W'(Q32_ONE) + DEN_W'(big_r);
  assign n_nxt = (NUM_W'(Q32_ONE - big_r) << (DATA_WIDTH - 1)) + NUM_W'(d_nxt >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= EXP_STAGES; i++) begin
        side_r[i] <= '0;
      end
    end else if (en) begin
      side_r[1] <= side_nxt;
      for (int i = 2; i <= EXP_STAGES; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a24_r  <= a24_nxt;
      pm_r   <= pm_nxt;
      a24b_r <= a24_r;
      k_r[3] <= p_s3[61:56];
      f_r    <= p_s3[55:24];
      for (int i = 4; i <= 14; i++) begin
        k_r[i] <= k_r[i-1];
      end
      h_r[4] <= h_nxt;
      for (int i = 5; i <= 9; i++) begin
        h_r[i] <= h_r[i-1];
      end
      q5_r   <= q5_prod[59:34];
      m4_r   <= m4_nxt;
      m3_r   <= m3_nxt;
      q3_r   <= q3_nxt;
      m2_r   <= m2_nxt;
      m1_r   <= m1_nxt;
      e1_r   <= e1_nxt;
      e2_r   <= e2_nxt;
      e3_r   <= e3_nxt;
      e4_r   <= e4_nxt;
      big_r  <= big_nxt;
      n_r    <= n_nxt;
      d_r    <= d_nxt;
    end
  end

  assign out_side = side_r[EXP_STAGES];
  assign out_n    = n_r;
  assign out_d    = d_r;

endmodule

@@ sv/rtu_div.sv @@
// ============================================================================
// rtu_div: pipelined restoring divider
// one quotient bit per stage, dividend bits shift out as quotient bits
// shift in, so the quotient lands in the same word after the last stage
// ============================================================================
module rtu_div
  import rtu_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  side_t                  in_side,
  input  logic [DATA_WIDTH+31:0] in_n,
  input  logic [DEN_W-1:0]       in_d,
  output side_t                  out_side,
  output logic [DATA_WIDTH-1:0]  out_q
);

  side_t                 side_r [DATA_WIDTH];
  logic [DEN_W-1:0]      rem_r  [DATA_WIDTH];
  logic [DEN_W-1:0]      d_r    [DATA_WIDTH];
  logic [DATA_WIDTH-1:0] nq_r   [DATA_WIDTH];

  for (genvar j = 0; j < DATA_WIDTH; j++) begin : g_step
    side_t                 side_src;
    logic [DEN_W-1:0]      rem_src, d_src, rem_nxt;
    logic [DATA_WIDTH-1:0] nq_src, nq_nxt;
    logic [DEN_W:0]        trial;
    logic                  fits;

    if (j == 0) begin : g_head
      // upper dividend bits are already below the divisor
      assign side_src = in_side;
      assign rem_src  = DEN_W'(in_n[DATA_WIDTH+31:DATA_WIDTH]);
      assign nq_src   = in_n[DATA_WIDTH-1:0];
      assign d_src    = in_d;
    end else begin : g_link
      assign side_src = side_r[j-1];
      assign rem_src  = rem_r[j-1];
      assign nq_src   = nq_r[j-1];
      assign d_src    = d_r[j-1];
    end

    assign trial   = {rem_src, nq_src[DATA_WIDTH-1]};
    assign fits    = (trial >= {1'b0, d_src});
    assign rem_nxt = fits ? DEN_W'(trial - {1'b0, d_src}) : trial[DEN_W-1:0];
    assign nq_nxt  = {nq_src[DATA_WIDTH-2:0], fits};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[j] <= '0;
      end else if (en) begin
        side_r[j] <= side_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= rem_nxt;
        nq_r[j]  <= nq_nxt;
        d_r[j]   <= d_src;
      end
    end
  end

  assign out_side = side_r[DATA_WIDTH-1];
  assign out_q    = nq_r[DATA_WIDTH-1];

endmodule

@@ sv/rtu_out.sv @@
// ============================================================================
// rtu_out: result formatting and output skid buffer
// applies the zero and saturation cases and the sign, then holds the beat
// in an output register backed by one skid register
// ============================================================================
module rtu_out
  import rtu_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  side_t                 in_side,
  input  logic [DATA_WIDTH-1:0] in_q,
  output logic                  en,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] out_y,
  output logic                  out_last
);

  localparam logic [DATA_WIDTH-1:0] MAX_MAG = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  logic [DATA_WIDTH-1:0] mag, y_new;

  always_comb begin
    if (in_side.zero) begin
      mag = '0;
    end else if (in_side.sat || (in_q > MAX_MAG)) begin
      mag = MAX_MAG;
    end else begin
      mag = in_q;
    end
    y_new = in_side.neg ? (~mag + 1'b1) : mag;
  end

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [DATA_WIDTH-1:0] out_y_r, out_y_nxt;
  logic                  skid_valid_r, skid_valid_nxt;
  logic                  skid_last_r, skid_last_nxt;
  logic [DATA_WIDTH-1:0] skid_y_r, skid_y_nxt;

  // the pipe moves only while the skid register is free
  assign en = !skid_valid_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_last_nxt   = out_last_r;
    out_y_nxt      = out_y_r;
    skid_valid_nxt = skid_valid_r;
    skid_last_nxt  = skid_last_r;
    skid_y_nxt     = skid_y_r;
    if (!skid_valid_r) begin
      if (out_valid_r && !out_ready) begin
        // output held, park any arriving beat
        skid_valid_nxt = in_side.valid;
        skid_last_nxt  = in_side.last;
        skid_y_nxt     = y_new;
      end else begin
        out_valid_nxt = in_side.valid;
        out_last_nxt  = in_side.last;
        out_y_nxt     = y_new;
      end
    end else if (out_ready) begin
      out_valid_nxt  = 1'b1;
      out_last_nxt   = skid_last_r;
      out_y_nxt      = skid_y_r;
      skid_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_last_r  <= out_last_nxt;
    out_y_r     <= out_y_nxt;
    skid_last_r <= skid_last_nxt;
    skid_y_r    <= skid_y_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_y     = out_y_r;
  assign out_last  = out_last_r;

endmodule

@@ sv/real_tanh_unit_top.sv @@
// ============================================================================
// real_tanh_unit_top: streaming fixed-point hyperbolic tangent
// one signed sample per beat in, tanh of it as signed q1.(DATA_WIDTH-1) out
// ============================================================================
// usage
//   in_*  : sample beats, in_tdata carries the signed argument x with
//           IN_FRAC_BITS fraction bits, in_tlast marks the end of a vector
//   out_* : result beats, out_tdata carries tanh(x), magnitude limited to
//           2^(DATA_WIDTH-1)-1, out_tlast is the matching input flag
// throughput: one beat per clock cycle, sustained while out_tready stays high
// pipe: a beat passes the 16 stages of the exponential front end and one
//   divider stage per result bit before it loads the output register
// stall: when out_tready is low the result waits in the output register and
//   the pipe keeps moving until one more beat sits in the skid register;
//   in_tready then drops until the receiver takes a beat, nothing is lost
// reset: rst_n low clears every valid bit, both channels come up empty
// ============================================================================
module real_tanh_unit_top
  import rtu_pkg::*;
#(
  parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
  parameter int IN_FRAC_BITS = IN_FRAC_BITS_DEF,
  localparam int TDATA_W     = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // sample channel
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // x_in, zero padding above
  input  logic               in_tlast,
  // result channel
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // y_out, zero padding above
  output logic               out_tlast
);

  // global advance of every pipe stage, owned by the output buffer
  logic en;

  side_t                  exp_side, div_side;
  logic [DATA_WIDTH+31:0] exp_n;
  logic [DEN_W-1:0]       exp_d;
  logic [DATA_WIDTH-1:0]  div_q;
  logic [DATA_WIDTH-1:0]  y;

  // a beat is taken whenever the pipe advances
  assign in_tready = en;

  // e^(-2|x|) and the dividend / divisor of (1 - E) / (1 + E)
  rtu_exp #(
    .DATA_WIDTH   (DATA_WIDTH),
    .IN_FRAC_BITS (IN_FRAC_BITS)
  ) u_exp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_x     (in_tdata[DATA_WIDTH-1:0]),
    .in_last  (in_tlast),
    .out_side (exp_side),
    .out_n    (exp_n),
    .out_d    (exp_d)
  );

  // rounded magnitude, one bit per stage
  rtu_div #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_side  (exp_side),
    .in_n     (exp_n),
    .in_d     (exp_d),
    .out_side (div_side),
    .out_q    (div_q)
  );

  // zero and saturation cases, sign, output and skid registers
  rtu_out #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_side   (div_side),
    .in_q      (div_q),
    .en        (en),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_y     (y),
    .out_last  (out_tlast)
  );

  assign out_tdata = TDATA_W'(y);

endmodule
